FILE: hdl/pfe_pkg.sv
package pfe_pkg;

  // Square geometry and letter codes.
  localparam int SQUARE_SIDE = 5;
  localparam int CELLS       = SQUARE_SIDE * SQUARE_SIDE;
  localparam int LETTERS     = 26;

  localparam logic [4:0] CODE_I      = 5'd8;
  localparam logic [4:0] CODE_J      = 5'd9;
  localparam logic [4:0] CODE_X      = 5'd23;
  localparam logic [4:0] LAST_LETTER = 5'd25;

  // Input command codes.
  localparam logic [1:0] CMD_KEY    = 2'd0;
  localparam logic [1:0] CMD_FINISH = 2'd1;
  localparam logic [1:0] CMD_PLAIN  = 2'd2;

  // Queue between front and back.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [1:0] cmd;
    logic [4:0] letter;
    logic       msg_last;
  } in_item_t;

  typedef struct packed {
    logic [4:0] cipher_letter;
    logic       run_last;
    logic       msg_end;
  } out_item_t;

  // Classified operation handed from the front to the back.
  typedef enum logic [1:0] {
    OP_KEY    = 2'd0,
    OP_FINISH = 2'd1,
    OP_PLAIN  = 2'd2
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] letter;
    logic       last;
  } op_item_t;

  // Status of the back end, watched at the top level.
  typedef struct packed {
    logic [4:0] fill;
    logic       sq_ready;
    logic       walking;
  } back_status_t;

  // Row of a square position: p / 5 through a reciprocal, exact for p < 32.
  function automatic logic [2:0] pos_row(input logic [4:0] p);
    logic [9:0] prod;
    prod = {5'b00000, p} * 10'd13;
    return prod[8:6];
  endfunction

  // Column of a square position: p % 5.
  function automatic logic [2:0] pos_col(input logic [4:0] p);
    logic [4:0] base;
    base = 5'({2'b00, pos_row(p)} * 5'(SQUARE_SIDE));
    return 3'(p - base);
  endfunction

  // Next row or column, wrapping at the edge of the square.
  function automatic logic [2:0] wrap_inc(input logic [2:0] x);
    return (x == 3'(SQUARE_SIDE - 1)) ? 3'd0 : 3'(x + 3'd1);
  endfunction

  // Position of a cell in row-major order.
  function automatic logic [4:0] cell_idx(input logic [2:0] r, input logic [2:0] c);
    return 5'({2'b00, r} * 5'(SQUARE_SIDE)) + {2'b00, c};
  endfunction

endpackage

FILE: hdl/playfair_cipher_encryptor_core.sv
// Playfair encryptor on letter codes 0 (A) to 25 (Z). Key letters build the 5x5 square,
// a finish command completes it, and plaintext letters then come out as ciphertext
// transactions, one letter per cycle at most, with run_last on the last letter caused by
// an input and msg_end on the last letter of a message. Inputs go through a four-entry
// queue, so in_ready stays high while the back end works until four operations wait
// in it. The back end handles a key letter in its idle state, walks the alphabet for a
// finish command, and for a plaintext letter feeds each letter it adds to the pair stream
// (one to three) and, for every pair it completes (up to two pairs), runs the sequence of
// position lookups and square reads through the single read port of each memory and
// then hands both letters to the output register, where they wait on out_ready.
module playfair_cipher_encryptor_core
  import pfe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic          q_push, q_pop, q_full, q_empty;
  logic [Q_AW:0] q_count;
  op_item_t      q_in, q_out;
  back_status_t  status;

  // Front end: classification of incoming transactions.
  pfe_front u_front (
    .in_valid (in_valid),
    .in_item  (in_item),
    .q_full   (q_full),
    .in_ready (in_ready),
    .push     (q_push),
    .op_item  (q_in)
  );

  // Queue of classified operations.
  pfe_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .pop_item  (q_out),
    .full      (q_full),
    .empty     (q_empty),
    .count     (q_count)
  );

  // Back end: key square, pairing and encryption.
  pfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (!q_empty),
    .op_item   (q_out),
    .op_pop    (q_pop),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .status    (status)
  );

  // A finished square holds every cell.
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    status.sq_ready |-> (status.fill == 5'(CELLS)))
    else $error("square marked ready before all cells are filled");

  // The square becomes ready only at the end of the alphabet walk.
  a_ready_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(status.sq_ready) |-> $past(status.walking))
    else $error("square became ready outside the finish walk");

  // The queue never holds more than its depth.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= (Q_AW+1)'(Q_DEPTH))
    else $error("operation queue overflow");

endmodule

FILE: hdl/pfe_front.sv
module pfe_front
  import pfe_pkg::*;
(
  input  logic     in_valid,
  input  in_item_t in_item,
  input  logic     q_full,
  output logic     in_ready,
  output logic     push,
  output op_item_t op_item
);

  logic keep;

  // Take a transaction whenever the queue has room.
  assign in_ready = !q_full;

  // Classify the command and drop letters out of range and unused codes.
  // J shares the cell of I everywhere.
  always_comb begin
    keep           = 1'b0;
    op_item.op     = OP_KEY;
    op_item.letter = (in_item.letter == CODE_J) ? CODE_I : in_item.letter;
    op_item.last   = in_item.msg_last;
    unique case (in_item.cmd)
      CMD_KEY: begin
        keep       = (in_item.letter <= LAST_LETTER);
        op_item.op = OP_KEY;
      end
      CMD_FINISH: begin
        keep       = 1'b1;
        op_item.op = OP_FINISH;
      end
      CMD_PLAIN: begin
        keep       = (in_item.letter <= LAST_LETTER);
        op_item.op = OP_PLAIN;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = in_valid && in_ready && keep;

endmodule

FILE: hdl/pfe_fifo.sv
module pfe_fifo
  import pfe_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  op_item_t      push_item,
  input  logic          pop,
  output op_item_t      pop_item,
  output logic          full,
  output logic          empty,
  output logic [Q_AW:0] count
);

  op_item_t        mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full     = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign empty    = (count_r == '0);
  assign count    = count_r;
  assign pop_item = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = do_push ? Q_AW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? Q_AW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = (Q_AW+1)'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = (Q_AW+1)'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: hdl/pfe_back.sv
module pfe_back
  import pfe_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         op_valid,
  input  op_item_t     op_item,
  output logic         op_pop,
  input  logic         out_ready,
  output logic         out_valid,
  output out_item_t    out_item,
  output back_status_t status
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_FIN  = 9'b000000010,
    ST_PUSH = 9'b000000100,
    ST_LPA  = 9'b000001000,
    ST_LPB  = 9'b000010000,
    ST_SQA  = 9'b000100000,
    ST_SQB  = 9'b001000000,
    ST_OUT1 = 9'b010000000,
    ST_OUT2 = 9'b100000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [25:0] used_r, used_nxt;
  logic [4:0]  fill_r, fill_nxt;
  logic        ready_r, ready_nxt;
  logic        pend_v_r, pend_v_nxt;
  logic [4:0]  pend_r, pend_nxt;
  logic        prev_v_r, prev_v_nxt;
  logic [4:0]  prev_r, prev_nxt;
  logic [4:0]  walk_r, walk_nxt;
  logic [4:0]  cur_c_r, cur_c_nxt;
  logic        cur_dup_r, cur_dup_nxt;
  logic [1:0]  cur_t_r, cur_t_nxt;
  logic        cur_last_r, cur_last_nxt;
  logic [1:0]  j_r, j_nxt;
  logic [4:0]  e_r, e_nxt;
  logic        lastpair_r, lastpair_nxt;
  logic [4:0]  pa_r, pa_nxt;
  logic [4:0]  c2_r, c2_nxt;
  logic [4:0]  l1_r, l1_nxt;
  logic [4:0]  l2_r, l2_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r, out_nxt;

  // Key square and letter position memories.
  logic [4:0] sq_mem_r [CELLS];
  logic [4:0] lp_mem_r [LETTERS];
  logic [4:0] sq_rd_r, lp_rd_r;
  logic [4:0] sq_raddr, lp_raddr;
  logic       wr_en;
  logic [4:0] wr_letter, wr_pos;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign status    = '{fill: fill_r, sq_ready: ready_r, walking: (state_r == ST_FIN)};

  // Letter of the expanded stream at push index j of the current plaintext letter.
  function automatic logic [4:0] stream_letter(input logic [1:0] j, input logic dup,
                                               input logic [4:0] c);
    logic [4:0] e;
    e = CODE_X;
    if (j == 2'd0) begin
      e = dup ? CODE_X : c;
    end else if (j == 2'd1) begin
      e = dup ? c : CODE_X;
    end
    return e;
  endfunction

  always_comb begin
    logic        slot_free;
    logic        place_en, can_place;
    logic [4:0]  place_c;
    logic [25:0] used_base;
    logic [4:0]  fill_base;
    logic        dup, pend_after, pad;
    logic [4:0]  e;
    logic [1:0]  j1;
    logic [2:0]  ra, ca, rb, cb;
    logic [4:0]  c1, c2;

    state_nxt     = state_r;
    used_nxt      = used_r;
    fill_nxt      = fill_r;
    ready_nxt     = ready_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    prev_v_nxt    = prev_v_r;
    prev_nxt      = prev_r;
    walk_nxt      = walk_r;
    cur_c_nxt     = cur_c_r;
    cur_dup_nxt   = cur_dup_r;
    cur_t_nxt     = cur_t_r;
    cur_last_nxt  = cur_last_r;
    j_nxt         = j_r;
    e_nxt         = e_r;
    lastpair_nxt  = lastpair_r;
    pa_nxt        = pa_r;
    c2_nxt        = c2_r;
    l1_nxt        = l1_r;
    l2_nxt        = l2_r;
    out_nxt       = out_r;
    slot_free     = !out_valid_r || out_ready;
    out_valid_nxt = out_valid_r && !out_ready;
    op_pop        = 1'b0;
    place_en      = 1'b0;
    place_c       = op_item.letter;
    used_base     = used_r;
    fill_base     = fill_r;
    lp_raddr      = e_r;
    sq_raddr      = c2_r;
    dup           = 1'b0;
    pend_after    = 1'b0;
    pad           = 1'b0;
    e             = stream_letter(j_r, cur_dup_r, cur_c_r);
    j1            = 2'(j_r + 2'd1);
    ra            = pos_row(pa_r);
    ca            = pos_col(pa_r);
    rb            = pos_row(lp_rd_r);
    cb            = pos_col(lp_rd_r);
    c1            = cell_idx(ra, cb);
    c2            = cell_idx(rb, ca);

    unique case (state_r)
      // Take the next operation from the queue.
      ST_IDLE: begin
        if (op_valid) begin
          op_pop = 1'b1;
          unique case (op_item.op)
            OP_KEY: begin
              if (ready_r) begin
                used_base  = '0;
                fill_base  = '0;
                ready_nxt  = 1'b0;
                pend_v_nxt = 1'b0;
                prev_v_nxt = 1'b0;
              end
              place_en = 1'b1;
              place_c  = op_item.letter;
            end
            OP_FINISH: begin
              if (!ready_r) begin
                walk_nxt  = '0;
                state_nxt = ST_FIN;
              end
            end
            OP_PLAIN: begin
              if (ready_r) begin
                dup          = prev_v_r && (prev_r == op_item.letter);
                pend_after   = pend_v_r ^ !dup;
                pad          = op_item.last && pend_after;
                cur_c_nxt    = op_item.letter;
                cur_dup_nxt  = dup;
                cur_t_nxt    = 2'(2'd1 + {1'b0, dup} + {1'b0, pad});
                cur_last_nxt = op_item.last;
                j_nxt        = '0;
                prev_nxt     = op_item.letter;
                prev_v_nxt   = !op_item.last;
                state_nxt    = ST_PUSH;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      // Append the unused letters in alphabet order, J left out.
      ST_FIN: begin
        place_en = (walk_r != CODE_J);
        place_c  = walk_r;
        walk_nxt = 5'(walk_r + 5'd1);
        if (walk_r == LAST_LETTER) begin
          ready_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      // Feed one stream letter: hold it as half a pair or start encrypting a pair.
      ST_PUSH: begin
        j_nxt = j1;
        if (!pend_v_r) begin
          pend_nxt   = e;
          pend_v_nxt = 1'b1;
          if (j1 == cur_t_r) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          lp_raddr     = pend_r;
          e_nxt        = e;
          lastpair_nxt = ({1'b0, j_r} + 3'd2 >= {1'b0, cur_t_r});
          pend_v_nxt   = 1'b0;
          state_nxt    = ST_LPA;
        end
      end

      ST_LPA: begin
        pa_nxt    = lp_rd_r;
        lp_raddr  = e_r;
        state_nxt = ST_LPB;
      end

      // Choose the two ciphertext cells by the row, column or rectangle rule.
      ST_LPB: begin
        if (ra == rb) begin
          c1 = cell_idx(ra, wrap_inc(ca));
          c2 = cell_idx(rb, wrap_inc(cb));
        end else if (ca == cb) begin
          c1 = cell_idx(wrap_inc(ra), ca);
          c2 = cell_idx(wrap_inc(rb), cb);
        end
        sq_raddr  = c1;
        c2_nxt    = c2;
        state_nxt = ST_SQA;
      end

      ST_SQA: begin
        l1_nxt    = sq_rd_r;
        sq_raddr  = c2_r;
        state_nxt = ST_SQB;
      end

      ST_SQB: begin
        l2_nxt    = sq_rd_r;
        state_nxt = ST_OUT1;
      end

      // Hand the pair to the output register, one letter per transaction.
      ST_OUT1: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{cipher_letter: l1_r, run_last: 1'b0, msg_end: 1'b0};
          state_nxt     = ST_OUT2;
        end
      end

      ST_OUT2: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{cipher_letter: l2_r, run_last: lastpair_r,
                            msg_end: lastpair_r && cur_last_r};
          state_nxt     = (j_r == cur_t_r) ? ST_IDLE : ST_PUSH;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Place a letter into the next free cell unless it is already there.
    can_place = place_en && !used_base[place_c] && (fill_base < 5'(CELLS));
    wr_en     = can_place;
    wr_letter = place_c;
    wr_pos    = fill_base;
    if (place_en) begin
      used_nxt = used_base;
      fill_nxt = fill_base;
    end
    if (can_place) begin
      used_nxt[place_c] = 1'b1;
      fill_nxt          = 5'(fill_base + 5'd1);
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      fill_r      <= '0;
      ready_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      prev_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      fill_r      <= fill_nxt;
      ready_r     <= ready_nxt;
      pend_v_r    <= pend_v_nxt;
      prev_v_r    <= prev_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    prev_r     <= prev_nxt;
    walk_r     <= walk_nxt;
    cur_c_r    <= cur_c_nxt;
    cur_dup_r  <= cur_dup_nxt;
    cur_t_r    <= cur_t_nxt;
    cur_last_r <= cur_last_nxt;
    j_r        <= j_nxt;
    e_r        <= e_nxt;
    lastpair_r <= lastpair_nxt;
    pa_r       <= pa_nxt;
    c2_r       <= c2_nxt;
    l1_r       <= l1_nxt;
    l2_r       <= l2_nxt;
    out_r      <= out_nxt;
  end

  // Memories: one write and one registered read each per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      sq_mem_r[wr_pos]    <= wr_letter;
      lp_mem_r[wr_letter] <= wr_pos;
    end
    sq_rd_r <= sq_mem_r[sq_raddr];
    lp_rd_r <= lp_mem_r[lp_raddr];
  end

endmodule
